@@ sv/assert_macros.svh @@
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define DHSA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define DHSA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/dhsa_pkg.sv @@
package dhsa_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int ANGLE_BITS     = 16;
    localparam int MAX_POLE_PAIRS = 64;
    localparam int CORDIC_STEPS   = 20;
    localparam int AMP_BITS       = 20;
    localparam int CORD_BITS      = 28;
    localparam int FIFO_DEPTH     = 2;
    localparam int PTR_BITS       = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_BITS       = $clog2(FIFO_DEPTH + 1);

    // Register indexes of the configuration port.
    localparam logic [0:0] REG_POLE_PAIRS   = 1'b0;
    localparam logic [0:0] REG_FILTER_SHIFT = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sine;
        logic signed [SAMPLE_BITS-1:0] cosine;
        logic                          zero;
    } item_t;

    typedef struct packed {
        logic [6:0] pole_pairs;
        logic [3:0] filter_shift;
    } cfg_t;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:    r = 32'd536870912;
            5'd1:    r = 32'd316933406;
            5'd2:    r = 32'd167458907;
            5'd3:    r = 32'd85004756;
            5'd4:    r = 32'd42667331;
            5'd5:    r = 32'd21354465;
            5'd6:    r = 32'd10679838;
            5'd7:    r = 32'd5340245;
            5'd8:    r = 32'd2670163;
            5'd9:    r = 32'd1335087;
            5'd10:   r = 32'd667544;
            5'd11:   r = 32'd333772;
            5'd12:   r = 32'd166886;
            5'd13:   r = 32'd83443;
            5'd14:   r = 32'd41722;
            5'd15:   r = 32'd20861;
            5'd16:   r = 32'd10430;
            5'd17:   r = 32'd5215;
            5'd18:   r = 32'd2608;
            5'd19:   r = 32'd1304;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

@@ sv/dhsa_front.sv @@
module dhsa_front import dhsa_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        full,
    output logic        push,
    output item_t       item
);

    logic  valid_reg, valid_next;
    item_t item_reg, item_next;

    assign s_tready = !valid_reg;
    assign push     = valid_reg && !full;
    assign item     = item_reg;

    // The input word is held here and tagged when both samples are zero.
    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (push) begin
            valid_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            valid_next       = 1'b1;
            item_next.sine   = $signed(s_tdata[15:0]);
            item_next.cosine = $signed(s_tdata[31:16]);
            item_next.zero   = (s_tdata == 32'd0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

endmodule

@@ sv/dhsa_fifo.sv @@
module dhsa_fifo import dhsa_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t wr_item,
    output logic  full,
    input  logic  pop,
    output logic  empty,
    output item_t rd_item
);

    item_t                mem_reg [FIFO_DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;

    assign full    = (count_reg == CNT_BITS'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_item = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push && !full) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop && !empty) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if ((push && !full) && !(pop && !empty)) begin
            count_next = count_reg + 1'b1;
        end else if (!(push && !full) && (pop && !empty)) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push && !full) begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

@@ sv/dhsa_back.sv @@
module dhsa_back import dhsa_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        item_valid,
    input  item_t       item,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    output logic [0:0]  m_tuser
);

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b00000000001,
        ST_SQ_C     = 11'b00000000010,
        ST_SQRT     = 11'b00000000100,
        ST_DIV_LOAD = 11'b00000001000,
        ST_DIV      = 11'b00000010000,
        ST_FILT     = 11'b00000100000,
        ST_ATAN     = 11'b00001000000,
        ST_CORD     = 11'b00010000000,
        ST_COUNT    = 11'b00100000000,
        ST_SHAFT    = 11'b01000000000,
        ST_DONE     = 11'b10000000000
    } state_t;

    localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
    localparam logic [ANGLE_BITS-1:0] HALF    = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
    localparam logic [ANGLE_BITS-1:0] THREE_Q = QUARTER + HALF;

    state_t state_reg, state_next;

    logic signed [15:0] s_reg, s_next, c_reg, c_next;
    logic               zero_reg, zero_next;
    logic [31:0]        sq_reg, sq_next;
    logic [39:0]        rad_reg, rad_next;
    logic [19:0]        root_reg, root_next;
    logic [23:0]        rem_reg, rem_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [15:0]        quo_reg, quo_next;
    logic [35:0]        num_reg, num_next;
    logic               sel_reg, sel_next;
    logic signed [15:0] nsin_reg, nsin_next, ncos_reg, ncos_next;
    logic signed [15:0] ysin_reg, ysin_next, ycos_reg, ycos_next;
    logic signed [CORD_BITS-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [31:0]        acc_reg, acc_next;
    logic [15:0]        angle_reg, angle_next;
    logic [15:0]        prev_reg, prev_next;
    logic [5:0]         period_reg, period_next;
    logic               m_valid_reg, m_valid_next;
    logic [39:0]        m_data_reg, m_data_next;
    logic               m_user_reg, m_user_next;

    logic signed [31:0] prod;
    logic [31:0]        mag2;
    logic [23:0]        sq_rem, sq_trial;
    logic signed [15:0] dv;
    logic [16:0]        dmag;
    logic [35:0]        dnum;
    logic [20:0]        drem;
    logic               qbit;
    logic [15:0]        qfull, qclamp;
    logic signed [16:0] qsigned;
    logic signed [16:0] fd_s, fd_c;
    logic signed [CORD_BITS-1:0] xs, ys;
    logic [31:0]        acc_fin;
    logic [6:0]         ppc;
    logic signed [7:0]  pcnt;
    logic [7:0]         srem;

    assign pop      = (state_reg == ST_IDLE) && item_valid;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    always_comb begin
        if (cfg.pole_pairs == 7'd0) begin
            ppc = 7'd1;
        end else if (cfg.pole_pairs > 7'(MAX_POLE_PAIRS)) begin
            ppc = 7'(MAX_POLE_PAIRS);
        end else begin
            ppc = cfg.pole_pairs;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_next       = s_reg;
        c_next       = c_reg;
        zero_next    = zero_reg;
        sq_next      = sq_reg;
        rad_next     = rad_reg;
        root_next    = root_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        quo_next     = quo_reg;
        num_next     = num_reg;
        sel_next     = sel_reg;
        nsin_next    = nsin_reg;
        ncos_next    = ncos_reg;
        ysin_next    = ysin_reg;
        ycos_next    = ycos_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        acc_next     = acc_reg;
        angle_next   = angle_reg;
        prev_next    = prev_reg;
        period_next  = period_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;

        prod     = '0;
        mag2     = '0;
        sq_rem   = '0;
        sq_trial = '0;
        dv       = sel_reg ? c_reg : s_reg;
        dmag     = '0;
        dnum     = '0;
        drem     = '0;
        qbit     = 1'b0;
        qfull    = '0;
        qclamp   = '0;
        qsigned  = '0;
        fd_s     = '0;
        fd_c     = '0;
        xs       = cx_reg >>> cnt_reg;
        ys       = cy_reg >>> cnt_reg;
        acc_fin  = '0;
        pcnt     = '0;
        srem     = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (item_valid) begin
                    s_next    = item.sine;
                    c_next    = item.cosine;
                    zero_next = item.zero;
                    prod      = item.sine * item.sine;
                    sq_next   = unsigned'(prod);
                    state_next = item.zero ? ST_ATAN : ST_SQ_C;
                end
            end
            ST_SQ_C: begin
                prod       = c_reg * c_reg;
                mag2       = sq_reg + unsigned'(prod);
                rad_next   = {mag2, 8'd0};
                rem_next   = '0;
                root_next  = '0;
                cnt_next   = 5'(AMP_BITS - 1);
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                // One result bit per cycle, two radicand bits brought down.
                sq_rem   = {rem_reg[21:0], rad_reg[39:38]};
                sq_trial = {2'b00, root_reg, 2'b01};
                if (sq_rem >= sq_trial) begin
                    rem_next  = sq_rem - sq_trial;
                    root_next = {root_reg[18:0], 1'b1};
                end else begin
                    rem_next  = sq_rem;
                    root_next = {root_reg[18:0], 1'b0};
                end
                rad_next = {rad_reg[37:0], 2'b00};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    sel_next   = 1'b0;
                    state_next = ST_DIV_LOAD;
                end
            end
            ST_DIV_LOAD: begin
                dmag       = dv[15] ? 17'(-$signed({dv[15], dv})) : {1'b0, dv};
                dnum       = {1'b0, dmag, 18'd0} + 36'(root_reg >> 1);
                num_next   = dnum;
                rem_next   = {4'd0, dnum[35:16]};
                quo_next   = '0;
                cnt_next   = 5'd15;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                drem = {rem_reg[19:0], num_reg[15]};
                if (drem >= {1'b0, root_reg}) begin
                    qbit     = 1'b1;
                    rem_next = {3'd0, drem - {1'b0, root_reg}};
                end else begin
                    rem_next = {3'd0, drem};
                end
                num_next = {num_reg[34:0], 1'b0};
                quo_next = {quo_reg[14:0], qbit};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    qfull   = {quo_reg[14:0], qbit};
                    qclamp  = (qfull > 16'd16384) ? 16'd16384 : qfull;
                    qsigned = dv[15] ? -$signed({1'b0, qclamp}) : $signed({1'b0, qclamp});
                    if (sel_reg) begin
                        ncos_next  = qsigned[15:0];
                        state_next = ST_FILT;
                    end else begin
                        nsin_next  = qsigned[15:0];
                        sel_next   = 1'b1;
                        state_next = ST_DIV_LOAD;
                    end
                end
            end
            ST_FILT: begin
                fd_s      = 17'(nsin_reg) - 17'(ysin_reg);
                fd_c      = 17'(ncos_reg) - 17'(ycos_reg);
                ysin_next = 16'(17'(ysin_reg) + (fd_s >>> cfg.filter_shift));
                ycos_next = 16'(17'(ycos_reg) + (fd_c >>> cfg.filter_shift));
                state_next = ST_ATAN;
            end
            ST_ATAN: begin
                if (ysin_reg == '0 && ycos_reg == '0) begin
                    angle_next = '0;
                    state_next = ST_COUNT;
                end else if (ysin_reg == '0) begin
                    angle_next = (ycos_reg > 0) ? '0 : HALF;
                    state_next = ST_COUNT;
                end else if (ycos_reg == '0) begin
                    angle_next = (ysin_reg > 0) ? QUARTER : THREE_Q;
                    state_next = ST_COUNT;
                end else begin
                    // Left half plane is turned by half a turn first.
                    if (ycos_reg < 0) begin
                        cx_next  = -(CORD_BITS'(ycos_reg) <<< 8);
                        cy_next  = -(CORD_BITS'(ysin_reg) <<< 8);
                        acc_next = 32'h8000_0000;
                    end else begin
                        cx_next  = CORD_BITS'(ycos_reg) <<< 8;
                        cy_next  = CORD_BITS'(ysin_reg) <<< 8;
                        acc_next = '0;
                    end
                    cnt_next   = '0;
                    state_next = ST_CORD;
                end
            end
            ST_CORD: begin
                if (cy_reg > 0) begin
                    cx_next  = cx_reg + ys;
                    cy_next  = cy_reg - xs;
                    acc_next = acc_reg + atan_turn(cnt_reg);
                end else begin
                    cx_next  = cx_reg - ys;
                    cy_next  = cy_reg + xs;
                    acc_next = acc_reg - atan_turn(cnt_reg);
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'(CORDIC_STEPS - 1)) begin
                    acc_fin    = acc_next + (32'd1 << (31 - ANGLE_BITS));
                    angle_next = acc_fin[31 -: ANGLE_BITS];
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT: begin
                pcnt = $signed({2'b00, period_reg});
                if (angle_reg < QUARTER && prev_reg >= THREE_Q) begin
                    pcnt = pcnt + 8'sd1;
                end else if (angle_reg > THREE_Q && prev_reg <= QUARTER) begin
                    pcnt = pcnt - 8'sd1;
                end
                if (pcnt < 0) begin
                    pcnt = $signed({1'b0, ppc}) - 8'sd1;
                end else if (pcnt >= $signed({1'b0, ppc})) begin
                    pcnt = '0;
                end
                period_next = pcnt[5:0];
                prev_next   = angle_reg;
                rem_next    = {18'd0, pcnt[5:0]};
                num_next    = {20'd0, angle_reg};
                quo_next    = '0;
                cnt_next    = 5'd15;
                state_next  = ST_SHAFT;
            end
            ST_SHAFT: begin
                srem = {rem_reg[6:0], num_reg[15]};
                if (srem >= {1'b0, ppc}) begin
                    qbit     = 1'b1;
                    rem_next = {16'd0, srem - {1'b0, ppc}};
                end else begin
                    rem_next = {16'd0, srem};
                end
                num_next = {num_reg[34:0], 1'b0};
                quo_next = {quo_reg[14:0], qbit};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {2'b00, period_reg, angle_reg, quo_reg};
                    m_user_next  = zero_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            ysin_reg    <= '0;
            ycos_reg    <= '0;
            prev_reg    <= '0;
            period_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            ysin_reg    <= ysin_next;
            ycos_reg    <= ycos_next;
            prev_reg    <= prev_next;
            period_reg  <= period_next;
        end
        s_reg      <= s_next;
        c_reg      <= c_next;
        zero_reg   <= zero_next;
        sq_reg     <= sq_next;
        rad_reg    <= rad_next;
        root_reg   <= root_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        quo_reg    <= quo_next;
        num_reg    <= num_next;
        sel_reg    <= sel_next;
        nsin_reg   <= nsin_next;
        ncos_reg   <= ncos_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        acc_reg    <= acc_next;
        angle_reg  <= angle_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

endmodule

@@ sv/dual_hall_shaft_angle_top.sv @@
// Channel   | Direction | Payload
// s_        | in        | tdata: sine_sample, cosine_sample (16 bits each, signed)
// m_        | out       | tdata: shaft_angle, pair_angle, pair_index; tuser: zero_magnitude
// cfg_      | in        | index 0 pole_pairs, index 1 filter_shift
//
// A nonzero word passes the squares, a 20-step root, two divides, filter, angle setup,
// a 20-step CORDIC, count, a 16-step divide by the pole pairs and the output load.
// An all-zero word goes straight from the queue to the angle setup; a smoothed pair on
// an axis skips the CORDIC. Reset is synchronous, active low, and clears state.
// The front register and a two-word queue keep taking input until both are full while the
// back end works or while a finished word waits on m_tready.
module dual_hall_shaft_angle_top import dhsa_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] sine_sample, [31:16] cosine_sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [15:0] shaft_angle, [31:16] pair_angle,
                                   // [37:32] pair_index, [39:38] zero fill
    output logic [0:0]  m_tuser,   // [0] zero_magnitude
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [6:0]  cfg_wdata
);

    cfg_t  cfg_reg, cfg_next;
    item_t front_item;
    item_t queue_item;
    logic  push;
    logic  full;
    logic  empty;
    logic  pop;

    // Configuration writes land directly in the register file.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_POLE_PAIRS:   cfg_next.pole_pairs   = cfg_wdata;
                REG_FILTER_SHIFT: cfg_next.filter_shift = cfg_wdata[3:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pole_pairs   <= 7'd1;
            cfg_reg.filter_shift <= 4'd4;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // The front end captures a word and flags an all-zero sample pair.
    dhsa_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .full     (full),
        .push     (push),
        .item     (front_item)
    );

    // The short queue decouples the capture side from the arithmetic engine.
    dhsa_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .wr_item  (front_item),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .rd_item  (queue_item)
    );

    // The back end runs the whole angle computation one word at a time.
    dhsa_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .item_valid (!empty),
        .item       (queue_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

@@ sv/dhsa_checker.sv @@
`include "assert_macros.svh"

module dhsa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    `DHSA_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "result dropped")
    `DHSA_ASSERT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata), "data moved")
    `DHSA_ASSERT(a_no_burst, aclk, aresetn, m_tvalid && m_tready |=> !m_tvalid, "results too close")
    `DHSA_ASSERT(a_fill_zero, aclk, aresetn, m_tvalid |-> m_tdata[39:38] == 2'b00, "padding set")
    `DHSA_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_tvalid, "valid after reset")

endmodule

bind dual_hall_shaft_angle_top dhsa_checker u_dhsa_checker (.*);
